// ----- hdl/pss_pkg.sv -----
// Shared types, widths and codes for the positional sequence store.
`default_nettype none
package pss_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_FWD  = 3'd6;
    localparam logic [OP_W-1:0] OP_READ_BACK = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    localparam logic [2:0] CA_HOLD = 3'd0;
    localparam logic [2:0] CA_INS  = 3'd1;
    localparam logic [2:0] CA_DEL  = 3'd2;
    localparam logic [2:0] CA_ROTL = 3'd3;
    localparam logic [2:0] CA_ROTR = 3'd4;

    typedef struct packed {
        logic [2:0]        action;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- hdl/pss_cell.sv -----
// One storage cell of the element chain, shifting with its neighbors.
`default_nettype none
module pss_cell #(
    parameter int CAPACITY = pss_pkg::CAPACITY_DEF,
    parameter int CELL_ID  = 0
) (
    input  wire logic                            i_clk,
    input  wire pss_pkg::t_cell_ctl              i_ctl,
    input  wire logic [$clog2(CAPACITY)-1:0]     i_index,
    input  wire logic [pss_pkg::DATA_W-1:0]      i_left,
    input  wire logic [pss_pkg::DATA_W-1:0]      i_right,
    output logic      [pss_pkg::DATA_W-1:0]      o_val
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_ID = IW'(CELL_ID);

    logic [pss_pkg::DATA_W-1:0] r_val;
    logic [pss_pkg::DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.action)
            pss_pkg::CA_INS: begin
                if (MY_ID > i_index) begin
                    n_val = i_left;
                end else if (MY_ID == i_index) begin
                    n_val = i_ctl.value;
                end
            end
            pss_pkg::CA_DEL: begin
                if (MY_ID >= i_index) begin
                    n_val = i_right;
                end
            end
            pss_pkg::CA_ROTL: n_val = i_right;
            pss_pkg::CA_ROTR: n_val = i_left;
            default:          n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

// ----- hdl/positional_sequence_store_unit.sv -----
// Top level: sequencer, result register and the chain of element cells.
//
//  Channel  | Dir | Handshake                         | Payload
//  ---------+-----+-----------------------------------+------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: op, value, position
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | tdata: status, element,
//           |     |                                   | length; tlast: last
//
// Inserts, deletes and reads of an empty list give one beat each.
// A read-out rotates the whole chain once around, one place per cycle unless an
// output stall holds it, keeps the input held off until the rotation is done, and
// emits one beat per element as it passes the end cell.
// A beat waiting in the output register stalls rotation only when a new beat is due.
// Reset clears the element count and the control state; cell contents are not reset.
`default_nettype none
module positional_sequence_store_unit #(
    parameter int CAPACITY = pss_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // op [2:0], value [34:3], position [41:35], zero [47:42]
    input  wire logic [pss_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // status [1:0], element [33:2], length [40:34], zero [47:41]
    output logic      [pss_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = pss_pkg::LEN_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [OW-1:0] OCC_MAX = OW'(CAPACITY);
    localparam logic [IW-1:0] CNT_END = IW'(CAPACITY - 1);

    logic [pss_pkg::OP_W-1:0]   w_op;
    logic [pss_pkg::DATA_W-1:0] w_value;
    logic [pss_pkg::POS_W-1:0]  w_pos;

    assign w_op    = i_s_axis_tdata[pss_pkg::OP_W-1:0];
    assign w_value = i_s_axis_tdata[pss_pkg::OP_W +: pss_pkg::DATA_W];
    assign w_pos   = i_s_axis_tdata[pss_pkg::OP_W + pss_pkg::DATA_W +: pss_pkg::POS_W];

    logic                        r_state, n_state;
    logic                        r_dir, n_dir;
    logic [IW-1:0]               r_cnt, n_cnt;
    logic [OW-1:0]               r_occ, n_occ;
    logic                        r_ovalid, n_ovalid;
    logic [pss_pkg::STAT_W-1:0]  r_ostat, n_ostat;
    logic [pss_pkg::DATA_W-1:0]  r_oelem, n_oelem;
    logic [pss_pkg::LEN_W-1:0]   r_olen, n_olen;
    logic                        r_olast, n_olast;

    pss_pkg::t_cell_ctl          w_ctl;
    logic [IW-1:0]               w_index;
    logic [pss_pkg::DATA_W-1:0]  w_val [CAPACITY];

    logic                        w_slot_free;
    logic                        w_accept;
    logic                        w_emit;
    logic                        w_advance;
    logic [CW-1:0]               w_pos_x;
    logic [CW-1:0]               w_occ_x;
    logic [OW-1:0]               w_cnt_x;

    assign w_slot_free     = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pos_x         = CW'(w_pos);
    assign w_occ_x         = CW'(r_occ);
    assign w_cnt_x         = OW'(r_cnt);

    always_comb begin
        n_state    = r_state;
        n_dir      = r_dir;
        n_cnt      = r_cnt;
        n_occ      = r_occ;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_ostat    = r_ostat;
        n_oelem    = r_oelem;
        n_olen     = r_olen;
        n_olast    = r_olast;
        w_ctl.action = pss_pkg::CA_HOLD;
        w_ctl.value  = w_value;
        w_index    = '0;
        w_emit     = 1'b0;
        w_advance  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_ostat  = pss_pkg::STAT_OK;
                    n_oelem  = '0;
                    n_olast  = 1'b1;
                    case (w_op)
                        pss_pkg::OP_INS_FIRST, pss_pkg::OP_INS_LAST,
                        pss_pkg::OP_INS_POS: begin
                            if (r_occ == OCC_MAX) begin
                                n_ostat = pss_pkg::STAT_FULL;
                            end else if (w_op == pss_pkg::OP_INS_FIRST) begin
                                w_ctl.action = pss_pkg::CA_INS;
                                w_index      = '0;
                                n_occ        = r_occ + OW'(1);
                            end else if (w_op == pss_pkg::OP_INS_LAST) begin
                                w_ctl.action = pss_pkg::CA_INS;
                                w_index      = IW'(r_occ);
                                n_occ        = r_occ + OW'(1);
                            end else if (w_pos_x == '0 || w_pos_x > w_occ_x + CW'(1)) begin
                                n_ostat = pss_pkg::STAT_RANGE;
                            end else begin
                                w_ctl.action = pss_pkg::CA_INS;
                                w_index      = IW'(w_pos_x - CW'(1));
                                n_occ        = r_occ + OW'(1);
                            end
                        end
                        pss_pkg::OP_DEL_FIRST, pss_pkg::OP_DEL_LAST,
                        pss_pkg::OP_DEL_POS: begin
                            if (r_occ == '0) begin
                                n_ostat = pss_pkg::STAT_EMPTY;
                            end else if (w_op == pss_pkg::OP_DEL_FIRST) begin
                                w_ctl.action = pss_pkg::CA_DEL;
                                w_index      = '0;
                                n_occ        = r_occ - OW'(1);
                            end else if (w_op == pss_pkg::OP_DEL_LAST) begin
                                w_ctl.action = pss_pkg::CA_DEL;
                                w_index      = IW'(r_occ - OW'(1));
                                n_occ        = r_occ - OW'(1);
                            end else if (w_pos_x == '0 || w_pos_x > w_occ_x) begin
                                n_ostat = pss_pkg::STAT_RANGE;
                            end else begin
                                w_ctl.action = pss_pkg::CA_DEL;
                                w_index      = IW'(w_pos_x - CW'(1));
                                n_occ        = r_occ - OW'(1);
                            end
                        end
                        default: begin
                            if (r_occ == '0) begin
                                n_ostat = pss_pkg::STAT_EMPTY;
                            end else begin
                                n_ovalid = r_ovalid && !i_m_axis_tready;
                                n_state  = ST_READ;
                                n_dir    = (w_op == pss_pkg::OP_READ_BACK);
                                n_cnt    = '0;
                            end
                        end
                    endcase
                    n_olen = pss_pkg::LEN_W'(n_occ);
                end
            end
            ST_READ: begin
                if (r_dir) begin
                    w_emit = w_cnt_x >= OCC_MAX - r_occ;
                end else begin
                    w_emit = w_cnt_x < r_occ;
                end
                w_advance = !w_emit || w_slot_free;
                if (w_advance) begin
                    w_ctl.action = r_dir ? pss_pkg::CA_ROTR : pss_pkg::CA_ROTL;
                    if (w_emit) begin
                        n_ovalid = 1'b1;
                        n_ostat  = pss_pkg::STAT_OK;
                        n_oelem  = r_dir ? w_val[CAPACITY-1] : w_val[0];
                        n_olen   = pss_pkg::LEN_W'(r_occ);
                        n_olast  = r_dir ? (r_cnt == CNT_END)
                                         : (w_cnt_x == r_occ - OW'(1));
                    end
                    if (r_cnt == CNT_END) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + IW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dir    <= 1'b0;
            r_cnt    <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dir    <= n_dir;
            r_cnt    <= n_cnt;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostat <= n_ostat;
        r_oelem <= n_oelem;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pss_cell #(
            .CAPACITY (CAPACITY),
            .CELL_ID  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (w_index),
            .i_left  (w_val[(g + CAPACITY - 1) % CAPACITY]),
            .i_right (w_val[(g + 1) % CAPACITY]),
            .o_val   (w_val[g])
        );
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = pss_pkg::M_TDATA_W'({r_olen, r_oelem, r_ostat});

endmodule
`default_nettype wire
